// ----- hw/rtl/npcs_pkg.sv -----
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types and constants of the nearest palette color search unit
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned SQ_W    = 2 * COLOR_W;
  localparam int unsigned DIST_W  = SQ_W + 2;

  localparam int unsigned SKIP_FIRST = 10;
  localparam int unsigned SKIP_END   = 246;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } rgb_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nearest_palette_color_search_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit
// palette store with a sequential nearest color search
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores one rgb palette entry and gives no result;
// writes to indexes at or beyond PALETTE_ENTRIES are dropped. A query item
// (tuser 1) scans the palette one entry per cycle through a single ram read
// port and a shared distance unit, and returns the index of the first entry
// with the least squared distance. A query searches PALETTE_ENTRIES entries,
// or entries 10 to 245 with skip_system set, and the input is not ready
// during that scan; a finished result waits in the output register while new
// items are taken. Entries must be written before a query reads them.
`default_nettype none

module nearest_palette_color_search_unit
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // entry_index[7:0], red[15:8], green[23:16], blue[31:24], skip_system[32]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // nearest_index[7:0]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CW = $clog2(PALETTE_ENTRIES + 1);
  localparam int unsigned SKIP_END_EFF =
    (SKIP_END < PALETTE_ENTRIES) ? SKIP_END : PALETTE_ENTRIES;
  localparam logic [CW-1:0] SKIP_START_C = CW'(
    (SKIP_FIRST < SKIP_END_EFF) ? SKIP_FIRST : SKIP_END_EFF);
  localparam logic [CW-1:0] SKIP_END_C   = CW'(SKIP_END_EFF);
  localparam logic [CW-1:0] FULL_END_C   = CW'(PALETTE_ENTRIES);
  localparam logic [IDX_W:0] ENTRIES_LIM = (IDX_W + 1)'(PALETTE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       addr_r, addr_nxt;
  logic [CW-1:0]       end_r, end_nxt;
  rgb_t                query_r, query_nxt;
  logic                p1_v_r, p1_v_nxt;
  logic                p1_last_r, p1_last_nxt;
  logic [AW-1:0]       p1_idx_r, p1_idx_nxt;
  logic                p2_v_r;
  logic                p2_last_r;
  logic [AW-1:0]       p2_idx_r;
  logic                have_r, have_nxt;
  logic [DIST_W-1:0]   best_d_r, best_d_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  logic                out_v_r, out_v_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;

  logic [IDX_W-1:0]    in_idx;
  rgb_t                in_rgb;
  logic                in_skip;
  logic                in_acc;
  logic                wr_en;
  logic                rd_en;
  logic [CW-1:0]       addr_inc;
  logic [CW-1:0]       start_c;
  logic [CW-1:0]       stop_c;
  rgb_t                entry_rgb;
  logic [DIST_W-1:0]   dist_sum;

  assign in_idx       = in_tdata[7:0];
  assign in_rgb.red   = in_tdata[15:8];
  assign in_rgb.green = in_tdata[23:16];
  assign in_rgb.blue  = in_tdata[31:24];
  assign in_skip      = in_tdata[32];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (in_tuser == FUNC_WRITE) && ({1'b0, in_idx} < ENTRIES_LIM);
  assign rd_en     = (state_r == ST_SCAN);
  assign addr_inc  = addr_r + CW'(1);
  assign start_c   = in_skip ? SKIP_START_C : '0;
  assign stop_c    = in_skip ? SKIP_END_C : FULL_END_C;

  npcs_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_idx[AW-1:0]),
    .wr_data (in_rgb),
    .rd_en   (rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (entry_rgb)
  );

  npcs_dist u_dist (
    .clk      (clk),
    .query    (query_r),
    .entry    (entry_rgb),
    .dist_sum (dist_sum)
  );

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    end_nxt      = end_r;
    query_nxt    = query_r;
    p1_v_nxt     = 1'b0;
    p1_last_nxt  = 1'b0;
    p1_idx_nxt   = addr_r[AW-1:0];
    have_nxt     = have_r;
    best_d_nxt   = best_d_r;
    best_idx_nxt = best_idx_r;
    out_v_nxt    = out_v_r;
    out_idx_nxt  = out_idx_r;

    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    if (p2_v_r && (!have_r || dist_sum < best_d_r)) begin
      have_nxt     = 1'b1;
      best_d_nxt   = dist_sum;
      best_idx_nxt = p2_idx_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == FUNC_QUERY) begin
          query_nxt    = in_rgb;
          addr_nxt     = start_c;
          end_nxt      = stop_c;
          have_nxt     = 1'b0;
          best_idx_nxt = '0;
          if (start_c >= stop_c) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        p1_v_nxt    = 1'b1;
        p1_last_nxt = (addr_inc == end_r);
        addr_nxt    = addr_inc;
        if (addr_inc == end_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (p2_v_r && p2_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt   = 1'b1;
          out_idx_nxt = IDX_W'(best_idx_r);
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      have_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p1_v_r    <= p1_v_nxt;
      p2_v_r    <= p1_v_r;
      have_r    <= have_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    end_r      <= end_nxt;
    query_r    <= query_nxt;
    p1_last_r  <= p1_last_nxt;
    p1_idx_r   <= p1_idx_nxt;
    p2_last_r  <= p1_last_r;
    p2_idx_r   <= p1_idx_r;
    best_d_r   <= best_d_nxt;
    best_idx_r <= best_idx_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_idx_r;

endmodule

`default_nettype wire

// ----- hw/rtl/npcs_ram.sv -----
// ----------------------------------------------------------------------------
// npcs_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/npcs_dist.sv -----
// ----------------------------------------------------------------------------
// npcs_dist
// squared euclidean distance unit, one palette entry per cycle, squares
// registered and summed on the way out
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_dist
  import npcs_pkg::*;
(
  input  logic              clk,
  input  rgb_t              query,
  input  rgb_t              entry,
  output logic [DIST_W-1:0] dist_sum
);

  logic [COLOR_W-1:0] diff_r_c;
  logic [COLOR_W-1:0] diff_g_c;
  logic [COLOR_W-1:0] diff_b_c;
  logic [SQ_W-1:0]    sq_red_r;
  logic [SQ_W-1:0]    sq_green_r;
  logic [SQ_W-1:0]    sq_blue_r;

  always_comb begin
    diff_r_c = (query.red > entry.red) ? query.red - entry.red : entry.red - query.red;
    diff_g_c = (query.green > entry.green) ? query.green - entry.green
                                           : entry.green - query.green;
    diff_b_c = (query.blue > entry.blue) ? query.blue - entry.blue
                                         : entry.blue - query.blue;
  end

  always_ff @(posedge clk) begin
    sq_red_r   <= SQ_W'(diff_r_c) * SQ_W'(diff_r_c);
    sq_green_r <= SQ_W'(diff_g_c) * SQ_W'(diff_g_c);
    sq_blue_r  <= SQ_W'(diff_b_c) * SQ_W'(diff_b_c);
  end

  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);

endmodule

`default_nettype wire

// ----- hw/rtl/npcs_checker.sv -----
// ----------------------------------------------------------------------------
// npcs_checker
// port level checks of the nearest palette color search unit
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_checker
  import npcs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic wr_acc;
  logic qry_acc;

  assign wr_acc  = in_tvalid && in_tready && (in_tuser == FUNC_WRITE);
  assign qry_acc = in_tvalid && in_tready && (in_tuser == FUNC_QUERY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item right after reset");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc && !out_tvalid |=> !out_tvalid)
    else $error("write item produced a result");

  a_write_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    wr_acc |=> in_tready)
    else $error("not ready after a write item");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    qry_acc |=> !in_tready)
    else $error("ready right after a query item");

endmodule

bind nearest_palette_color_search_unit npcs_checker u_npcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the nearest palette color search unit
// ----------------------------------------------------------------------------
// Loads the whole palette and then runs a short directed set of queries:
// black and white, ties between equal entries, and the edges of the
// non-system range. A random mix of writes and queries follows, in phases
// with and without sender gaps and receiver stalls. Many of the queried
// colors sit close to stored entries, and many stored colors repeat. An
// internal palette copy predicts every nearest index, and each result is
// checked in order against the queue of predicted indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import npcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_ENTRIES  = 256;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int RANDOM_ITEMS = 144;

  class palette_scoreboard;
    rgb_t             palette [PAL_ENTRIES];
    logic [IDX_W-1:0] nearest_q [$];
    int               mismatches;
    int               writes_seen;
    int               queries_seen;
    int               skip_queries;
    int               results_seen;

    function logic [DIST_W-1:0] color_dist(rgb_t a, rgb_t b);
      logic [COLOR_W-1:0] dr, dg, db;
      dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
      dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
      db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
      return DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg) +
             DIST_W'(db) * DIST_W'(db);
    endfunction

    function logic [IDX_W-1:0] search_nearest(rgb_t c, logic skip);
      int               lo, hi, best_i;
      logic [DIST_W-1:0] best_d, d;
      bit               found;
      lo = skip ? SKIP_FIRST : 0;
      hi = skip ? SKIP_END : PAL_ENTRIES;
      if (hi > PAL_ENTRIES) hi = PAL_ENTRIES;
      best_i = 0;
      best_d = '0;
      found  = 1'b0;
      for (int i = lo; i < hi; i++) begin
        d = color_dist(c, palette[i]);
        if (!found || d < best_d) begin
          best_d = d;
          best_i = i;
          found  = 1'b1;
        end
      end
      return best_i[IDX_W-1:0];
    endfunction

    function void note_item(logic func, logic [IDX_W-1:0] idx, rgb_t c, logic skip);
      if (func == FUNC_WRITE) begin
        if (idx < PAL_ENTRIES) palette[idx] = c;
        writes_seen++;
      end else begin
        nearest_q.push_back(search_nearest(c, skip));
        queries_seen++;
        if (skip) skip_queries++;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] tdata);
      logic [IDX_W-1:0] expected;
      results_seen++;
      if (nearest_q.size() == 0) begin
        report_mismatch($sformatf("nearest_index %0d with no query pending", tdata[IDX_W-1:0]));
      end else begin
        expected = nearest_q.pop_front();
        if (tdata[IDX_W-1:0] !== expected)
          report_mismatch($sformatf("nearest_index got %0d expected %0d (result %0d)",
                                    tdata[IDX_W-1:0], expected, results_seen));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // entry_index[7:0], red[15:8], green[23:16], blue[31:24], skip_system[32]
  logic [IN_TDATA_W-1:0]  in_tdata;
  // func[0]
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // nearest_index[7:0]
  logic [OUT_TDATA_W-1:0] out_tdata;

  palette_scoreboard sb = new();
  bit                tx_gaps;
  bit                rx_stalls;
  int                cycles;

  nearest_palette_color_search_unit #(
    .PALETTE_ENTRIES(PAL_ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 3);
  endfunction

  function rgb_t mk_rgb(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                        logic [COLOR_W-1:0] b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  // extremes, a coarse grid that repeats often, or anything
  function logic [COLOR_W-1:0] pick_component(int kind);
    case (kind)
      0:       return $urandom_range(0, 1) ? 8'hff : 8'h00;
      1:       return COLOR_W'(8'h40 * $urandom_range(1, 3));
      default: return COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function rgb_t pick_color();
    int kind;
    kind = $urandom_range(0, 5);
    return mk_rgb(pick_component(kind), pick_component(kind), pick_component(kind));
  endfunction

  function logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] x);
    int v;
    v = int'(x) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[COLOR_W-1:0];
  endfunction

  // receiver: ready high most of the time, short and occasional long stalls
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(logic func, logic [IDX_W-1:0] idx, rgb_t c, logic skip);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 1)) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'b0, skip, c.blue, c.green, c.red, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_item(func, idx, c, skip);
  endtask

  task automatic write_entry(logic [IDX_W-1:0] idx, rgb_t c);
    send_item(FUNC_WRITE, idx, c, 1'($urandom_range(0, 1)));
  endtask

  task automatic query(rgb_t c, logic skip);
    send_item(FUNC_QUERY, IDX_W'($urandom_range(0, 255)), c, skip);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.nearest_q.size() != 0);
  endtask

  initial begin
    rgb_t c;
    rgb_t p;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= 1'b0;
    in_tdata   <= '0;
    cycles     <= 0;
    tx_gaps    = 1'b1;
    rx_stalls  = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // full palette load, black at the bottom and white at the top
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      c = pick_color();
      if (i == 0) c = '0;
      if (i == PAL_ENTRIES - 1) c = '1;
      write_entry(i[IDX_W-1:0], c);
    end

    query(mk_rgb(8'h00, 8'h00, 8'h00), 1'b0);
    query(mk_rgb(8'hff, 8'hff, 8'hff), 1'b0);
    query(mk_rgb(8'h00, 8'h00, 8'h00), 1'b1);
    query(mk_rgb(8'hff, 8'hff, 8'hff), 1'b1);
    // equal entries inside the range, lowest index wins
    write_entry(8'd30, mk_rgb(8'h00, 8'h00, 8'h00));
    write_entry(8'd200, mk_rgb(8'h00, 8'h00, 8'h00));
    query(mk_rgb(8'h00, 8'h00, 8'h00), 1'b1);
    query(mk_rgb(8'h00, 8'h00, 8'h00), 1'b0);
    // last entry inside the range and first one past it
    write_entry(8'd245, mk_rgb(8'hff, 8'hff, 8'hff));
    write_entry(8'd246, mk_rgb(8'hff, 8'hff, 8'hff));
    query(mk_rgb(8'hff, 8'hff, 8'hff), 1'b1);
    query(mk_rgb(8'hff, 8'hff, 8'hff), 1'b0);
    // first entry inside the range against the system entry below it
    write_entry(8'd10, mk_rgb(8'd1, 8'd2, 8'd3));
    write_entry(8'd9, mk_rgb(8'd1, 8'd2, 8'd3));
    query(mk_rgb(8'd1, 8'd2, 8'd3), 1'b1);
    query(mk_rgb(8'd1, 8'd2, 8'd3), 1'b0);
    query(mk_rgb(8'hff, 8'h00, 8'hff), 1'b0);
    query(mk_rgb(8'h00, 8'hff, 8'h00), 1'b1);
    query(mk_rgb(8'h80, 8'h80, 8'h80), 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      tx_gaps   = phase[0];
      rx_stalls = phase[1];
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 45) begin
          write_entry(IDX_W'($urandom_range(0, 255)), pick_color());
        end else begin
          case ($urandom_range(0, 4))
            0, 1: begin
              p = sb.palette[IDX_W'($urandom_range(0, PAL_ENTRIES - 1))];
              c = mk_rgb(nudge(p.red), nudge(p.green), nudge(p.blue));
            end
            2:       c = pick_color();
            default: c = mk_rgb(COLOR_W'($urandom_range(0, 255)),
                                COLOR_W'($urandom_range(0, 255)),
                                COLOR_W'($urandom_range(0, 255)));
          endcase
          query(c, 1'($urandom_range(0, 1)));
        end
      end
      wait_drained();
    end

    repeat (2 * PAL_ENTRIES) @(posedge clk);
    $display("covered %0d palette writes and %0d searches, %0d of them over entries 10 to 245",
             sb.writes_seen, sb.queries_seen, sb.skip_queries);
    $display("%0d results checked under sender gaps and receiver stalls, %0d mismatches",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
